FILE: hw/rtl/rdmfp_pkg.sv
// shared types and constants of the rdm frame parser
package rdmfp_pkg;

  localparam logic [7:0] RDM_MIN_LEN = 8'd24;
  localparam logic [7:0] START_CODE_RESET = 8'd204;
  localparam logic [7:0] SUB_START_CODE_RESET = 8'd1;

  // configuration register indexes
  localparam logic CFG_START_CODE = 1'b0;
  localparam logic CFG_SUB_START_CODE = 1'b1;

  // result kinds
  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic        valid_res;
    logic [47:0] dst_uid;
    logic [47:0] src_uid;
    logic [7:0]  transaction_num;
    logic [7:0]  port_id;
    logic [7:0]  message_count;
    logic [15:0] sub_dev;
    logic [7:0]  command_class;
    logic [15:0] parameter_id;
    logic [7:0]  parameter_length;
    logic [7:0]  param_byte;
  } result_t;

  // handoff from the parse stage to the output register
  typedef struct packed {
    logic    load;
    result_t res;
  } res_push_t;

endpackage

FILE: hw/rtl/rdmfp_core.sv
// input register, frame state and per-byte parse logic
module rdmfp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                buffer_end_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                out_free_i,
  output rdmfp_pkg::res_push_t push_o
);

  typedef enum logic {
    PH_RECEIVING,
    PH_IGNORING
  } phase_e;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;

  logic [7:0]  start_code_q;
  logic [7:0]  sub_start_code_q;
  phase_e      phase_q, phase_d;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  ml_q, ml_d;
  logic [7:0]  pdl_q, pdl_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic [47:0] dest_q, dest_d;
  logic [47:0] src_q, src_d;
  logic [63:0] hdr_q, hdr_d;

  logic fail, done, ok, param, verdict, emit, step, restart;
  rdmfp_pkg::result_t res;

  always_comb begin
    fail     = 1'b0;
    done     = 1'b0;
    ok       = 1'b0;
    param    = 1'b0;
    ml_d     = ml_q;
    pdl_d    = pdl_q;
    chk_hi_d = chk_hi_q;
    dest_d   = dest_q;
    src_d    = src_q;
    hdr_d    = hdr_q;
    sum_d    = sum_q;
    if ((pos_q < 9'd3) || (pos_q < {1'b0, ml_q})) begin
      sum_d = sum_q + {8'h00, in_byte_q};
    end
    if (pos_q == 9'd0) begin
      fail = (in_byte_q != start_code_q);
    end else if (pos_q == 9'd1) begin
      fail = (in_byte_q != sub_start_code_q);
    end else if (pos_q == 9'd2) begin
      ml_d = in_byte_q;
      fail = (in_byte_q < rdmfp_pkg::RDM_MIN_LEN);
    end else if (pos_q < 9'd9) begin
      dest_d = {dest_q[39:0], in_byte_q};
    end else if (pos_q < 9'd15) begin
      src_d = {src_q[39:0], in_byte_q};
    end else if (pos_q < 9'd23) begin
      hdr_d = {hdr_q[55:0], in_byte_q};
    end else if (pos_q == 9'd23) begin
      pdl_d = in_byte_q;
      fail  = (ml_q != (rdmfp_pkg::RDM_MIN_LEN + in_byte_q));
    end else if (pos_q < {1'b0, ml_q}) begin
      param = 1'b1;
    end else if (pos_q == {1'b0, ml_q}) begin
      chk_hi_d = in_byte_q;
    end else begin
      done = 1'b1;
      ok   = ({chk_hi_q, in_byte_q} == sum_q);
    end
  end

  assign verdict = fail || done;

  always_comb begin
    res = '0;
    if (verdict || in_end_q) begin
      res.result_kind = rdmfp_pkg::KIND_VERDICT;
      if (verdict && ok && !fail) begin
        res.valid_res        = 1'b1;
        res.dst_uid          = dest_q;
        res.src_uid          = src_q;
        res.transaction_num  = hdr_q[63:56];
        res.port_id          = hdr_q[55:48];
        res.message_count    = hdr_q[47:40];
        res.sub_dev          = hdr_q[39:24];
        res.command_class    = hdr_q[23:16];
        res.parameter_id     = hdr_q[15:0];
        res.parameter_length = pdl_q;
      end
    end else begin
      res.result_kind = rdmfp_pkg::KIND_PARAM;
      res.param_byte  = in_byte_q;
    end
  end

  assign emit       = (phase_q == PH_RECEIVING) && (verdict || in_end_q || param);
  assign step       = in_valid_q && (!emit || out_free_i);
  assign in_ready_o = !in_valid_q || step;
  assign restart    = in_end_q;

  assign push_o.load = step && emit;
  assign push_o.res  = res;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    if (phase_q == PH_RECEIVING) begin
      if (verdict) begin
        phase_d = PH_IGNORING;
      end else begin
        pos_d = pos_q + 9'd1;
      end
    end
    // buffer end always starts a fresh frame
    if (restart) begin
      phase_d = PH_RECEIVING;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_end_q  <= buffer_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q     <= rdmfp_pkg::START_CODE_RESET;
      sub_start_code_q <= rdmfp_pkg::SUB_START_CODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rdmfp_pkg::CFG_START_CODE:     start_code_q     <= cfg_wdata_i;
        rdmfp_pkg::CFG_SUB_START_CODE: sub_start_code_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RECEIVING;
      pos_q   <= '0;
      sum_q   <= '0;
      ml_q    <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      if (restart) begin
        sum_q <= '0;
        ml_q  <= '0;
      end else if (phase_q == PH_RECEIVING) begin
        sum_q <= sum_d;
        ml_q  <= ml_d;
      end
    end
  end

  // header payload is fully rewritten before any accepted verdict reads it
  always_ff @(posedge clk_i) begin
    if (step && (phase_q == PH_RECEIVING)) begin
      pdl_q    <= pdl_d;
      chk_hi_q <= chk_hi_d;
      dest_q   <= dest_d;
      src_q    <= src_d;
      hdr_q    <= hdr_d;
    end
  end

endmodule

FILE: hw/rtl/rdmfp_out_reg.sv
// result register between the parse stage and the output channel
module rdmfp_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdmfp_pkg::res_push_t  push_i,
  output logic                  out_free_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rdmfp_pkg::result_t    res_o
);

  logic               valid_q;
  rdmfp_pkg::result_t res_q;

  assign out_free_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= push_i.load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && push_i.load) begin
      res_q <= push_i.res;
    end
  end

endmodule

FILE: hw/rtl/rdm_frame_parser.sv
// rdm frame parser top level
// Takes one buffer byte per transfer and reports parameter bytes as they arrive and one
// verdict per frame (start codes, message length, parameter length and 16-bit checksum),
// carrying the decoded header when the frame is good. One byte per cycle is sustained while
// the output accepts: a byte waits in the input register, where the frame state is updated,
// and its result, if any, is then registered in the output register. A stalled output holds
// the input register once a byte that produces a result is waiting behind it. Start code
// writes apply to the next compare; write them while no transfer is in flight.
module rdm_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_end_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic        valid_res_o,
  output logic [47:0] dst_uid_o,
  output logic [47:0] src_uid_o,
  output logic [7:0]  transaction_num_o,
  output logic [7:0]  port_id_o,
  output logic [7:0]  message_count_o,
  output logic [15:0] sub_dev_o,
  output logic [7:0]  command_class_o,
  output logic [15:0] parameter_id_o,
  output logic [7:0]  parameter_length_o,
  output logic [7:0]  param_byte_o
);

  rdmfp_pkg::res_push_t push;
  rdmfp_pkg::result_t   res;
  logic                 out_free;

  rdmfp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_free_i   (out_free),
    .push_o       (push)
  );

  rdmfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign result_kind_o      = res.result_kind;
  assign valid_res_o        = res.valid_res;
  assign dst_uid_o          = res.dst_uid;
  assign src_uid_o          = res.src_uid;
  assign transaction_num_o  = res.transaction_num;
  assign port_id_o          = res.port_id;
  assign message_count_o    = res.message_count;
  assign sub_dev_o          = res.sub_dev;
  assign command_class_o    = res.command_class;
  assign parameter_id_o     = res.parameter_id;
  assign parameter_length_o = res.parameter_length;
  assign param_byte_o       = res.param_byte;

endmodule

FILE: hw/rtl/rdmfp_checker.sv
// port-level checks of the rdm frame parser and their bind
module rdmfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic        valid_res_o,
  input logic [47:0] dst_uid_o,
  input logic [47:0] src_uid_o,
  input logic [15:0] parameter_id_o,
  input logic [7:0]  parameter_length_o,
  input logic [7:0]  param_byte_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(param_byte_o))
    else $error("stalled result dropped or changed");

  // parameter byte transfers carry no verdict or header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == rdmfp_pkg::KIND_PARAM) |->
      !valid_res_o && (dst_uid_o == '0) && (parameter_length_o == '0))
    else $error("parameter transfer with header content");

  // a rejected verdict has an empty header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == rdmfp_pkg::KIND_VERDICT) && !valid_res_o |->
      (dst_uid_o == '0) && (src_uid_o == '0) && (parameter_id_o == '0)
      && (parameter_length_o == '0) && (param_byte_o == '0))
    else $error("rejected verdict with header content");

  // a good frame never declares more parameter bytes than fit the length byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == rdmfp_pkg::KIND_VERDICT) && valid_res_o |->
      (parameter_length_o <= 8'd231) && (param_byte_o == '0))
    else $error("accepted verdict with bad parameter length");

endmodule

bind rdm_frame_parser rdmfp_checker u_rdmfp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .result_kind_o      (result_kind_o),
  .valid_res_o        (valid_res_o),
  .dst_uid_o          (dst_uid_o),
  .src_uid_o          (src_uid_o),
  .parameter_id_o     (parameter_id_o),
  .parameter_length_o (parameter_length_o),
  .param_byte_o       (param_byte_o)
);
